### hw/rtl/hsl_pkg.sv
// shared constants, stage payload structs and the ramp segment type
// for the hsl to rgb pipeline; no dependencies
`default_nettype none

package hsl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_BITS  = 16;
  localparam int IN_W      = 17;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int CMP_W     = (IN_W > VAL_W) ? IN_W : VAL_W;
  localparam int T6_W      = HUE_BITS + 3;
  localparam int F_W       = HUE_BITS + 1;

  localparam logic [VAL_W-1:0] FIX_ONE  = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] FIX_HALF = VAL_W'(1) << (FRAC_BITS - 1);

  // hue positions in units of 1/2^HUE_BITS of a sixth of a turn
  localparam logic [T6_W-1:0] HUE_UNIT   = T6_W'(1) << HUE_BITS;
  localparam logic [T6_W-1:0] THIRD_TURN = T6_W'(2) << HUE_BITS;
  localparam logic [T6_W-1:0] HOLD_END   = T6_W'(3) << HUE_BITS;
  localparam logic [T6_W-1:0] FALL_END   = T6_W'(4) << HUE_BITS;
  localparam logic [T6_W-1:0] SIX_TURN   = T6_W'(6) << HUE_BITS;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HOLD,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  typedef struct packed {
    logic                      zero;
    logic [VAL_W-1:0]          l;
    logic [VAL_W-1:0]          s;
    logic [VAL_W-1:0]          m;
    logic [2:0][T6_W-1:0]      t;
  } front_t;

  typedef struct packed {
    logic                      zero;
    logic [VAL_W-1:0]          l;
    logic [VAL_W-1:0]          q;
    logic [VAL_W-1:0]          p;
    logic [VAL_W-1:0]          d;
    seg_t [2:0]                seg;
    logic [2:0][F_W-1:0]       factor;
  } shape_t;

  typedef struct packed {
    logic                      zero;
    logic [VAL_W-1:0]          l;
    logic [VAL_W-1:0]          q;
    logic [VAL_W-1:0]          p;
    seg_t [2:0]                seg;
    logic [2:0][VAL_W-1:0]     prod;
  } blend_t;

  typedef logic [2:0][7:0] rgb_t;

endpackage

`default_nettype wire

### hw/rtl/hsl_front.sv
// stage 1: clamps saturation and lightness, forms l*s and the three hue offsets
// depends on hsl_pkg
`default_nettype none

module hsl_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [hsl_pkg::HUE_BITS-1:0] up_hue,
  input  wire logic [hsl_pkg::IN_W-1:0]    up_saturation,
  input  wire logic [hsl_pkg::IN_W-1:0]    up_lightness,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output hsl_pkg::front_t                  dn_data
);

  logic                               vld_r;
  hsl_pkg::front_t                    data_r;
  hsl_pkg::front_t                    data_nxt;
  logic [hsl_pkg::CMP_W-1:0]          sat_w;
  logic [hsl_pkg::CMP_W-1:0]          lit_w;
  logic [hsl_pkg::VAL_W-1:0]          s_c;
  logic [hsl_pkg::VAL_W-1:0]          l_c;
  logic [2*hsl_pkg::VAL_W-1:0]        ls_prod;
  logic [hsl_pkg::T6_W-1:0]           t6;
  logic [hsl_pkg::T6_W:0]             tr_sum;
  logic [hsl_pkg::T6_W:0]             tb_sum;
  logic [hsl_pkg::T6_W:0]             six_w;

  always_comb begin
    sat_w = hsl_pkg::CMP_W'(up_saturation);
    lit_w = hsl_pkg::CMP_W'(up_lightness);
    s_c = (sat_w > hsl_pkg::CMP_W'(hsl_pkg::FIX_ONE)) ? hsl_pkg::FIX_ONE
                                                       : hsl_pkg::VAL_W'(sat_w);
    l_c = (lit_w > hsl_pkg::CMP_W'(hsl_pkg::FIX_ONE)) ? hsl_pkg::FIX_ONE
                                                       : hsl_pkg::VAL_W'(lit_w);
    ls_prod = (2*hsl_pkg::VAL_W)'(l_c) * (2*hsl_pkg::VAL_W)'(s_c);

    // hue times six by shift and add
    t6 = (hsl_pkg::T6_W'(up_hue) << 2) + (hsl_pkg::T6_W'(up_hue) << 1);
    six_w = (hsl_pkg::T6_W+1)'(hsl_pkg::SIX_TURN);
    tr_sum = (hsl_pkg::T6_W+1)'(t6) + (hsl_pkg::T6_W+1)'(hsl_pkg::THIRD_TURN);
    tb_sum = (hsl_pkg::T6_W+1)'(t6) + (hsl_pkg::T6_W+1)'(hsl_pkg::FALL_END);
    // wrap one turn, sums stay below two turns
    if (tr_sum >= six_w) begin
      tr_sum = tr_sum - six_w;
    end
    if (tb_sum >= six_w) begin
      tb_sum = tb_sum - six_w;
    end

    data_nxt.zero = (s_c == '0);
    data_nxt.l    = l_c;
    data_nxt.s    = s_c;
    data_nxt.m    = ls_prod[hsl_pkg::FRAC_BITS +: hsl_pkg::VAL_W];
    data_nxt.t[0] = hsl_pkg::T6_W'(tr_sum);
    data_nxt.t[1] = t6;
    data_nxt.t[2] = hsl_pkg::T6_W'(tb_sum);
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### hw/rtl/hsl_qp.sv
// stage 2: forms q and p, and picks the ramp segment and hue factor per channel
// depends on hsl_pkg
`default_nettype none

module hsl_qp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire hsl_pkg::front_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output hsl_pkg::shape_t      dn_data
);

  logic                        vld_r;
  hsl_pkg::shape_t             data_r;
  hsl_pkg::shape_t             data_nxt;
  logic [hsl_pkg::VAL_W:0]     q_w;
  logic [hsl_pkg::VAL_W:0]     p_w;
  logic [hsl_pkg::T6_W-1:0]    t;
  logic [2:0]                  hold_vec;

  always_comb begin
    // l*(1+s) equals l + l*s exactly after truncation
    if (up_data.l < hsl_pkg::FIX_HALF) begin
      q_w = {1'b0, up_data.l} + {1'b0, up_data.m};
    end else begin
      q_w = {1'b0, up_data.l} + {1'b0, up_data.s} - {1'b0, up_data.m};
    end
    p_w = ({1'b0, up_data.l} << 1) - q_w;

    data_nxt.zero = up_data.zero;
    data_nxt.l    = up_data.l;
    data_nxt.q    = q_w[hsl_pkg::VAL_W-1:0];
    data_nxt.p    = p_w[hsl_pkg::VAL_W-1:0];
    data_nxt.d    = q_w[hsl_pkg::VAL_W-1:0] - p_w[hsl_pkg::VAL_W-1:0];

    for (int i = 0; i < 3; i++) begin
      t = up_data.t[i];
      data_nxt.factor[i] = '0;
      if (t < hsl_pkg::HUE_UNIT) begin
        data_nxt.seg[i]    = hsl_pkg::SEG_RISE;
        data_nxt.factor[i] = hsl_pkg::F_W'(t);
      end else if (t < hsl_pkg::HOLD_END) begin
        data_nxt.seg[i]    = hsl_pkg::SEG_HOLD;
      end else if (t < hsl_pkg::FALL_END) begin
        data_nxt.seg[i]    = hsl_pkg::SEG_FALL;
        data_nxt.factor[i] = hsl_pkg::F_W'(hsl_pkg::FALL_END - t);
      end else begin
        data_nxt.seg[i]    = hsl_pkg::SEG_LOW;
      end
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hold_vec[i] = (data_r.seg[i] == hsl_pkg::SEG_HOLD);
    end
  end

  // channels sit two sixths apart, so exactly one is on the plateau
  a_one_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> $onehot(hold_vec))
    else $error("hsl_qp: plateau not held by exactly one channel");

  a_qp_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (data_r.p <= data_r.q) && (data_r.d == data_r.q - data_r.p))
    else $error("hsl_qp: p above q or span mismatch");

  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> data_r.q <= hsl_pkg::FIX_ONE)
    else $error("hsl_qp: q above one");

  a_gray_flat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && data_r.zero |-> (data_r.q == data_r.l) && (data_r.p == data_r.l))
    else $error("hsl_qp: gray request with q or p off lightness");

endmodule

`default_nettype wire

### hw/rtl/hsl_blend.sv
// stage 3: scales the q-p span by the hue factor, one multiplier per channel
// depends on hsl_pkg
`default_nettype none

module hsl_blend (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire hsl_pkg::shape_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output hsl_pkg::blend_t      dn_data
);

  localparam int PROD_W = hsl_pkg::VAL_W + hsl_pkg::F_W;

  logic               vld_r;
  hsl_pkg::blend_t    data_r;
  hsl_pkg::blend_t    data_nxt;
  logic [PROD_W-1:0]  prod_w [3];

  always_comb begin
    data_nxt.zero = up_data.zero;
    data_nxt.l    = up_data.l;
    data_nxt.q    = up_data.q;
    data_nxt.p    = up_data.p;
    data_nxt.seg  = up_data.seg;
    for (int i = 0; i < 3; i++) begin
      prod_w[i] = PROD_W'(up_data.d) * PROD_W'(up_data.factor[i]);
      data_nxt.prod[i] = prod_w[i][hsl_pkg::HUE_BITS +: hsl_pkg::VAL_W];
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### hw/rtl/hsl_pack.sv
// stage 4: selects each channel value and scales it to a byte, output register
// depends on hsl_pkg
`default_nettype none

module hsl_pack (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire hsl_pkg::blend_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output hsl_pkg::rgb_t        dn_rgb
);

  localparam int SCL_W = hsl_pkg::VAL_W + 8;

  logic                       vld_r;
  hsl_pkg::rgb_t              rgb_r;
  hsl_pkg::rgb_t              rgb_nxt;
  logic [hsl_pkg::VAL_W-1:0]  v;
  logic [SCL_W-1:0]           scaled;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (up_data.zero) begin
        v = up_data.l;
      end else begin
        case (up_data.seg[i])
          hsl_pkg::SEG_RISE: v = up_data.p + up_data.prod[i];
          hsl_pkg::SEG_FALL: v = up_data.p + up_data.prod[i];
          hsl_pkg::SEG_HOLD: v = up_data.q;
          default:           v = up_data.p;
        endcase
      end
      // times 255 as times 256 minus one
      scaled = (SCL_W'(v) << 8) - SCL_W'(v);
      rgb_nxt[i] = scaled[hsl_pkg::FRAC_BITS +: 8];
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_rgb   = rgb_r;

endmodule

`default_nettype wire

### hw/rtl/hsl_to_rgb_converter_top.sv
// hsl to rgb converter, top level: four pipeline stages in a chain
// depends on hsl_pkg, hsl_front, hsl_qp, hsl_blend, hsl_pack
//
// usage:
//   input channel in_valid/in_ready carries hue (fraction of a turn),
//   saturation and lightness (1.0 = 65536, larger values clamp to 1.0).
//   output channel out_valid/out_ready carries 8-bit red, green, blue.
//   one result per request, in request order.
// pipeline: an accepted request passes four register stages (clamp and l*s
//   product, q/p and segment pick, span times hue factor, channel select
//   and byte scaling) before its result shows on out_*.
// throughput: one request per cycle while out_ready stays high; each stage holds one request and
//   takes a new one whenever it is empty or its own output moves on.
// reset: rst_n low clears all stage valid bits; no clearing pass, the
//   block takes requests in the first cycle after reset.
// stall: with out_ready low the result holds on out_*; earlier stages keep
//   filling empty slots, and in_ready drops once all four stages hold data.
`default_nettype none

module hsl_to_rgb_converter_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hsl_pkg::HUE_BITS-1:0] in_hue,
  input  wire logic [hsl_pkg::IN_W-1:0]     in_saturation,
  input  wire logic [hsl_pkg::IN_W-1:0]     in_lightness,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue
);

  logic             s1_valid;
  logic             s1_ready;
  hsl_pkg::front_t  s1_data;
  logic             s2_valid;
  logic             s2_ready;
  hsl_pkg::shape_t  s2_data;
  logic             s3_valid;
  logic             s3_ready;
  hsl_pkg::blend_t  s3_data;
  hsl_pkg::rgb_t    rgb;

  hsl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (in_valid),
    .up_ready      (in_ready),
    .up_hue        (in_hue),
    .up_saturation (in_saturation),
    .up_lightness  (in_lightness),
    .dn_valid      (s1_valid),
    .dn_ready      (s1_ready),
    .dn_data       (s1_data)
  );

  hsl_qp u_qp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  hsl_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  hsl_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_rgb   (rgb)
  );

  assign out_red   = rgb[0];
  assign out_green = rgb[1];
  assign out_blue  = rgb[2];

endmodule

`default_nettype wire

### bench/tb_hsl_to_rgb_converter_top.sv
// testbench for hsl_to_rgb_converter_top: random and corner hsl requests,
// results checked against an in-bench fixed-point color predictor
// depends on hsl_pkg and the converter rtl
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter_top;

  localparam int     HUE_W        = hsl_pkg::HUE_BITS;
  localparam int     LVL_W        = hsl_pkg::IN_W;
  localparam int     FRAC         = hsl_pkg::FRAC_BITS;
  localparam longint LVL_ONE      = longint'(1) << FRAC;
  localparam longint SIXTH        = longint'(1) << HUE_W;
  localparam longint FULL_TURN    = 6 * SIXTH;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  class rgb_scoreboard;
    pixel_t expected_rgb[$];
    int     failures;

    function new();
      failures = 0;
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction

    function longint ramp_level(longint p, longint q, longint t6);
      longint span;
      span = q - p;
      if (t6 < SIXTH) return p + ((span * t6) >>> HUE_W);
      if (t6 < 3 * SIXTH) return q;
      if (t6 < 4 * SIXTH) return p + ((span * (4 * SIXTH - t6)) >>> HUE_W);
      return p;
    endfunction

    function logic [7:0] scale_to_byte(longint v);
      if (v < 0) v = 0;
      if (v > LVL_ONE) v = LVL_ONE;
      return 8'((v * 255) >>> FRAC);
    endfunction

    function pixel_t predict_rgb(logic [HUE_W-1:0] hue, logic [LVL_W-1:0] sat_in,
                                 logic [LVL_W-1:0] light_in);
      longint sat, light, q, p, t6, t_red, t_blue;
      pixel_t px;
      sat   = sat_in;
      light = light_in;
      if (sat > LVL_ONE) sat = LVL_ONE;
      if (light > LVL_ONE) light = LVL_ONE;
      if (sat == 0) begin
        px.red   = scale_to_byte(light);
        px.green = px.red;
        px.blue  = px.red;
        return px;
      end
      if (2 * light < LVL_ONE) begin
        q = (light * (LVL_ONE + sat)) >>> FRAC;
      end else begin
        q = light + sat - ((light * sat) >>> FRAC);
      end
      p      = 2 * light - q;
      t6     = longint'(hue) * 6;
      // channel offsets of one third turn, wrapped to one turn
      t_red  = (t6 + 2 * SIXTH) % FULL_TURN;
      t_blue = (t6 + 4 * SIXTH) % FULL_TURN;
      px.red   = scale_to_byte(ramp_level(p, q, t_red));
      px.green = scale_to_byte(ramp_level(p, q, t6));
      px.blue  = scale_to_byte(ramp_level(p, q, t_blue));
      return px;
    endfunction

    function void note_request(logic [HUE_W-1:0] hue, logic [LVL_W-1:0] sat,
                               logic [LVL_W-1:0] light);
      expected_rgb.push_back(predict_rgb(hue, sat, light));
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (expected_rgb.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("error: result r=%0d g=%0d b=%0d with no request pending",
                   got.red, got.green, got.blue);
        return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        failures++;
        if (failures <= 10)
          $display("error: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [HUE_W-1:0] in_hue        = '0;
  logic [LVL_W-1:0] in_saturation = '0;
  logic [LVL_W-1:0] in_lightness  = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;

  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  bit            hold_req       = 1'b0;
  int            quiet_cycles   = 0;
  rgb_scoreboard rgb_board      = new();

  hsl_to_rgb_converter_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) rgb_board.note_request(in_hue, in_saturation, in_lightness);
      if (out_valid && out_ready) rgb_board.check_result({out_red, out_green, out_blue});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL hsl_to_rgb_converter_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [HUE_W-1:0] hue, input logic [LVL_W-1:0] sat,
                           input logic [LVL_W-1:0] light);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_lightness  <= light;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [LVL_W-1:0] pick_level();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return LVL_W'(LVL_ONE);
      2:       return LVL_W'($urandom_range(65537, 131071));  // clamps to one
      3:       return LVL_W'($urandom_range(32760, 32776));   // around one half
      4:       return LVL_W'($urandom_range(0, 15));
      default: return LVL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int k;
    if ($urandom_range(0, 3) == 0) begin
      // near a sixth-of-a-turn segment boundary
      k = $urandom_range(0, 6);
      return HUE_W'((k * 65536) / 6 + $urandom_range(0, 4) - 2);
    end
    return HUE_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(pick_hue(), pick_level(), pick_level());
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    // step the clock first so the last accepted request is already on the scoreboard
    @(posedge clk);
    while (rgb_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(16'd0,     17'd0,      17'd0);
    send_item(16'd65535, 17'd65536,  17'd65536);
    send_item(16'd12345, 17'd0,      17'd40000);   // zero saturation, gray
    send_item(16'd0,     17'd0,      17'd65536);
    send_item(16'd0,     17'd65536,  17'd32768);
    send_item(16'd10922, 17'd65536,  17'd32768);
    send_item(16'd10923, 17'd65536,  17'd32768);
    send_item(16'd21845, 17'd65536,  17'd32768);   // blue offset just short of a turn
    send_item(16'd21846, 17'd65536,  17'd32768);
    send_item(16'd32768, 17'd65536,  17'd32768);
    send_item(16'd43690, 17'd65536,  17'd32768);   // red offset just short of a turn
    send_item(16'd43691, 17'd65536,  17'd32768);
    send_item(16'd54613, 17'd65536,  17'd32768);
    send_item(16'd54614, 17'd65536,  17'd32768);
    send_item(16'd30000, 17'd131071, 17'd20000);   // saturation above one
    send_item(16'd5000,  17'd40000,  17'd131071);  // lightness above one
    send_item(16'd65535, 17'd131071, 17'd131071);
    send_item(16'd7000,  17'd50000,  17'd32767);
    send_item(16'd7000,  17'd50000,  17'd32768);
    send_item(16'd1,     17'd1,      17'd1);
    send_item(16'd65535, 17'd1,      17'd65535);
    send_item(16'd43690, 17'd65537,  17'd65537);
    wait_for_drain();

    // receiver holds off while requests keep coming, so the pipeline fills
    hold_req = 1'b1;
    send_random(300);
    wait_for_drain();

    send_idle_pct  = 83;
    recv_stall_pct = 0;
    send_random(400);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    send_random(200);
    wait_for_drain();
    send_random(200);
    wait_for_drain();

    send_idle_pct  = 12;
    recv_stall_pct = 12;
    send_random(450);
    wait_for_drain();

    if (rgb_board.failures == 0 && rgb_board.pending() == 0) begin
      $display("PASS hsl_to_rgb_converter_top");
    end else begin
      $display("failures: %0d, results never seen: %0d",
               rgb_board.failures, rgb_board.pending());
      $display("FAIL hsl_to_rgb_converter_top");
    end
    $finish;
  end

endmodule
